### hw/rtl/qcs_pkg.sv
// Shared types, constants and saturation helper for the quaternion constraint
// stabilizer. No dependencies; every other file of the block imports it.
package qcs_pkg;

	typedef logic signed [31:0] fx_t;
	typedef fx_t [3:0] fx4_t;

	typedef struct packed {
		logic operation;
		fx_t  quat_w;
		fx_t  quat_x;
		fx_t  quat_y;
		fx_t  quat_z;
		fx_t  rate_w;
		fx_t  rate_x;
		fx_t  rate_y;
		fx_t  rate_z;
	} qcs_in_t;

	typedef struct packed {
		fx_t  out_quat_w;
		fx_t  out_quat_x;
		fx_t  out_quat_y;
		fx_t  out_quat_z;
		fx_t  out_vec_w;
		fx_t  out_vec_x;
		fx_t  out_vec_y;
		fx_t  out_vec_z;
		logic was_normalized;
		logic saturated;
	} qcs_out_t;

	// A classified item as it sits in the queue between front and back.
	typedef struct packed {
		logic is_force;
		logic is_zero;
		fx4_t quat;
		fx4_t rate;
	} qcs_job_t;

	typedef struct packed {
		logic clip;
		fx_t  val;
	} sat_t;

	localparam logic OP_ENFORCE = 1'b0;
	localparam logic OP_FORCE   = 1'b1;

	localparam int QUEUE_DEPTH = 4;
	localparam int SQRT_STAGES = 33;
	localparam int DIV_STAGES  = 25;
	localparam int JOB_DELAY   = SQRT_STAGES + DIV_STAGES;

	localparam logic signed [71:0] S32_MAX_W = 72'sh7FFFFFFF;
	localparam logic signed [71:0] S32_MIN_W = -72'sh80000000;
	localparam logic signed [71:0] Q_ONE_W   = 72'sh1000000;

	function automatic sat_t sat32(input logic signed [71:0] x);
		sat_t r;
		if (x > S32_MAX_W) begin
			r.clip = 1'b1;
			r.val  = 32'sh7FFFFFFF;
		end else if (x < S32_MIN_W) begin
			r.clip = 1'b1;
			r.val  = 32'sh80000000;
		end else begin
			r.clip = 1'b0;
			r.val  = x[31:0];
		end
		return r;
	endfunction

endpackage

### hw/rtl/qcs_front.sv
// Front end: accepts input transactions, classifies them and holds them in a
// short queue for the back end. Depends on qcs_pkg.
module qcs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  qcs_pkg::qcs_in_t  item,
	output logic              head_valid,
	output qcs_pkg::qcs_job_t head,
	input  logic              pop
);
	import qcs_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	qcs_job_t        mem_q [0:QUEUE_DEPTH-1];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;
	qcs_job_t        job;
	logic            push;
	logic            pop_ok;

	// Classification: force transactions skip normalization, and a zero
	// quaternion has a zero norm and passes through unchanged.
	always_comb begin
		job.is_force = (item.operation == OP_FORCE);
		job.is_zero  = (item.quat_w == '0) && (item.quat_x == '0) &&
			(item.quat_y == '0) && (item.quat_z == '0);
		job.quat = {item.quat_z, item.quat_y, item.quat_x, item.quat_w};
		job.rate = {item.rate_z, item.rate_y, item.rate_x, item.rate_w};
	end

	assign item_ready = (count_q != (PW+1)'(QUEUE_DEPTH));
	assign push       = item_valid && item_ready;
	assign head_valid = (count_q != '0);
	assign pop_ok     = pop && head_valid;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop_ok) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop_ok) count_q <= count_q + 1'b1;
			else if (!push && pop_ok) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= job;
	end

endmodule

### hw/rtl/qcs_sqrt.sv
// Pipelined integer square root, one root bit per stage.
// Depends on qcs_pkg.
module qcs_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [64:0] radicand,
	output logic [32:0] root
);
	import qcs_pkg::*;

	logic [64:0] rem_s  [0:SQRT_STAGES];
	logic [32:0] root_s [0:SQRT_STAGES];

	assign rem_s[0]  = radicand;
	assign root_s[0] = '0;

	// Remainder form: rem holds radicand minus root squared.
	for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_stage
		localparam int I = SQRT_STAGES - k;
		logic [67:0] trial;
		logic        take;
		assign trial = (68'(root_s[k-1]) << (I + 1)) | (68'd1 << (2 * I));
		assign take  = 68'(rem_s[k-1]) >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? rem_s[k-1] - trial[64:0] : rem_s[k-1];
				root_s[k] <= take ? root_s[k-1] | (33'd1 << I) : root_s[k-1];
			end
		end
	end

	assign root = root_s[SQRT_STAGES];

endmodule

### hw/rtl/qcs_divide.sv
// Pipelined restoring divider, four lanes sharing one divisor, one quotient
// bit per stage. Depends on qcs_pkg.
module qcs_divide (
	input  logic             clk,
	input  logic             en,
	input  logic [32:0]      divisor,
	input  logic [3:0][31:0] mag,
	output logic [3:0][24:0] quot
);
	import qcs_pkg::*;

	logic [3:0][55:0] rem_s [0:DIV_STAGES];
	logic [3:0][24:0] quo_s [0:DIV_STAGES];
	logic [32:0]      dv_s  [0:DIV_STAGES];

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			rem_s[0][l] = {mag[l], 24'd0};
			quo_s[0][l] = '0;
		end
	end
	assign dv_s[0] = divisor;

	// The quotient never exceeds 2^24 because each magnitude is at most the norm.
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
		localparam int I = DIV_STAGES - k;
		logic [57:0] shifted;
		assign shifted = 58'(dv_s[k-1]) << I;
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= dv_s[k-1];
				for (int l = 0; l < 4; l++) begin
					if (58'(rem_s[k-1][l]) >= shifted) begin
						rem_s[k][l] <= rem_s[k-1][l] - shifted[55:0];
						quo_s[k][l] <= quo_s[k-1][l] | (25'd1 << I);
					end else begin
						rem_s[k][l] <= rem_s[k-1][l];
						quo_s[k][l] <= quo_s[k-1][l];
					end
				end
			end
		end
	end

	assign quot = quo_s[DIV_STAGES];

endmodule

### hw/rtl/qcs_back.sv
// Back end: norm, normalization, tangent projection and Baumgarte correction
// as one stalling pipeline ending in the result register.
// Depends on qcs_pkg, qcs_sqrt and qcs_divide.
module qcs_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  qcs_pkg::qcs_job_t head,
	output logic              pop,
	input  logic [31:0]       position_gain,
	input  logic [31:0]       velocity_gain,
	output logic              result_valid,
	input  logic              result_ready,
	output qcs_pkg::qcs_out_t result
);
	import qcs_pkg::*;

	typedef struct packed {
		logic is_force;
		logic normd;
		logic clip;
		fx4_t n;
		fx4_t pv;
	} ctx_t;

	// Signed element types keep each lane signed when it is selected.
	typedef logic signed [63:0] prod_t;
	typedef logic signed [64:0] psum_t;

	logic en;
	assign en  = !result_valid || result_ready;
	assign pop = head_valid && en;

	// Norm squared.
	logic                    vld_s1, vld_s2, vld_s3;
	qcs_job_t                job_s1, job_s2, job_s3;
	logic [3:0][63:0]        sq_s1;
	logic [1:0][64:0]        sq2_s2;
	logic [64:0]             sum_s3;

	qcs_job_t                job_dl_q [1:JOB_DELAY];
	logic                    vld_dl_q [1:JOB_DELAY];

	logic [32:0]             root;
	logic [3:0][31:0]        mag;
	logic [3:0][24:0]        quot;

	always_ff @(posedge clk) begin
		if (en) begin
			job_s1 <= head;
			for (int i = 0; i < 4; i++)
				sq_s1[i] <= 64'($signed(head.quat[i]) * $signed(head.quat[i]));
			job_s2    <= job_s1;
			sq2_s2[0] <= 65'(sq_s1[0]) + 65'(sq_s1[1]);
			sq2_s2[1] <= 65'(sq_s1[2]) + 65'(sq_s1[3]);
			job_s3    <= job_s2;
			sum_s3    <= sq2_s2[0] + sq2_s2[1];
			job_dl_q[1] <= job_s3;
			for (int i = 2; i <= JOB_DELAY; i++) job_dl_q[i] <= job_dl_q[i-1];
		end
	end

	qcs_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s3),
		.root     (root)
	);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag[i] = job_dl_q[SQRT_STAGES].quat[i][31] ?
				32'(-job_dl_q[SQRT_STAGES].quat[i]) : job_dl_q[SQRT_STAGES].quat[i];
		end
	end

	qcs_divide u_divide (
		.clk     (clk),
		.en      (en),
		.divisor (root),
		.mag     (mag),
		.quot    (quot)
	);

	// Post-division stages.
	logic vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;
	ctx_t ctx_s4, ctx_s5, ctx_s6, ctx_s7, ctx_s8, ctx_s9, ctx_s10;
	ctx_t ctx_s11, ctx_s12, ctx_s13, ctx_s14, ctx_s15;

	prod_t [3:0]             nv_s5;
	psum_t [1:0]             nv2_s6;
	fx_t                     d_s7;
	prod_t [3:0]             dn_s8;
	prod_t [3:0]             nn_s10, np_s10;
	psum_t [1:0]             nn2_s11, np2_s11;
	fx_t                     g_s12, gd_s12;
	logic signed [64:0]      ga_s13, gb_s13;
	fx_t                     lam_s14;
	prod_t [3:0]             fl_s15;

	ctx_t                    c4, c7, c9, c12, c14;
	qcs_job_t                jd;
	logic signed [65:0]      tot_nv, tot_nn, tot_np;
	sat_t                    sd, sg, sgd, sl;
	sat_t [3:0]              st, sp;

	always_comb begin
		jd          = job_dl_q[JOB_DELAY];
		c4.is_force = jd.is_force;
		c4.normd    = !jd.is_force && !jd.is_zero;
		c4.clip     = 1'b0;
		c4.pv       = jd.rate;
		for (int i = 0; i < 4; i++) begin
			if (c4.normd) begin
				c4.n[i] = jd.quat[i][31] ? -$signed(32'(quot[i])) : $signed(32'(quot[i]));
			end else begin
				c4.n[i] = jd.quat[i];
			end
		end

		tot_nv  = 66'(nv2_s6[0]) + 66'(nv2_s6[1]);
		sd      = sat32(72'(tot_nv >>> 24));
		c7      = ctx_s6;
		c7.clip = ctx_s6.clip | (sd.clip & !ctx_s6.is_force);

		c9 = ctx_s8;
		for (int i = 0; i < 4; i++) begin
			st[i] = sat32(72'(dn_s8[i] >>> 24));
			sp[i] = sat32(72'($signed(ctx_s8.pv[i])) - 72'($signed(st[i].val)));
			if (!ctx_s8.is_force) begin
				c9.pv[i] = sp[i].val;
				c9.clip  = c9.clip | st[i].clip | sp[i].clip;
			end
		end

		tot_nn   = 66'(nn2_s11[0]) + 66'(nn2_s11[1]);
		tot_np   = 66'(np2_s11[0]) + 66'(np2_s11[1]);
		sg       = sat32(72'(tot_nn >>> 24) - Q_ONE_W);
		sgd      = sat32(72'(tot_np >>> 23));
		c12      = ctx_s11;
		c12.clip = ctx_s11.clip | sg.clip | sgd.clip;

		sl       = sat32(-(72'(ga_s13 >>> 24) + 72'(gb_s13 >>> 24)));
		c14      = ctx_s13;
		c14.clip = ctx_s13.clip | sl.clip;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s4 <= c4;
			ctx_s5 <= ctx_s4;
			for (int i = 0; i < 4; i++)
				nv_s5[i] <= $signed(ctx_s4.n[i]) * $signed(ctx_s4.pv[i]);
			ctx_s6    <= ctx_s5;
			nv2_s6[0] <= 65'(nv_s5[0]) + 65'(nv_s5[1]);
			nv2_s6[1] <= 65'(nv_s5[2]) + 65'(nv_s5[3]);
			ctx_s7 <= c7;
			d_s7   <= sd.val;
			ctx_s8 <= ctx_s7;
			for (int i = 0; i < 4; i++)
				dn_s8[i] <= $signed(d_s7) * $signed(ctx_s7.n[i]);
			ctx_s9  <= c9;
			ctx_s10 <= ctx_s9;
			for (int i = 0; i < 4; i++) begin
				nn_s10[i] <= $signed(ctx_s9.n[i]) * $signed(ctx_s9.n[i]);
				np_s10[i] <= $signed(ctx_s9.n[i]) * $signed(ctx_s9.pv[i]);
			end
			ctx_s11    <= ctx_s10;
			nn2_s11[0] <= 65'(nn_s10[0]) + 65'(nn_s10[1]);
			nn2_s11[1] <= 65'(nn_s10[2]) + 65'(nn_s10[3]);
			np2_s11[0] <= 65'(np_s10[0]) + 65'(np_s10[1]);
			np2_s11[1] <= 65'(np_s10[2]) + 65'(np_s10[3]);
			ctx_s12 <= c12;
			g_s12   <= sg.val;
			gd_s12  <= sgd.val;
			ctx_s13 <= ctx_s12;
			ga_s13  <= $signed({1'b0, position_gain}) * $signed(g_s12);
			gb_s13  <= $signed({1'b0, velocity_gain}) * $signed(gd_s12);
			ctx_s14 <= c14;
			lam_s14 <= sl.val;
			ctx_s15 <= ctx_s14;
			for (int i = 0; i < 4; i++)
				fl_s15[i] <= $signed(lam_s14) * $signed(ctx_s14.n[i]);
		end
	end

	// Final correction and result assembly.
	qcs_out_t   res;
	sat_t [3:0] sf, sv;
	fx4_t       vec;
	logic       clip_out;

	always_comb begin
		clip_out = ctx_s15.clip;
		for (int i = 0; i < 4; i++) begin
			sf[i] = sat32(72'(fl_s15[i] >>> 23));
			sv[i] = sat32(72'($signed(ctx_s15.pv[i])) + 72'($signed(sf[i].val)));
			if (ctx_s15.is_force) begin
				vec[i]   = sf[i].val;
				clip_out = clip_out | sf[i].clip;
			end else begin
				vec[i]   = sv[i].val;
				clip_out = clip_out | sf[i].clip | sv[i].clip;
			end
		end
		res.out_quat_w     = ctx_s15.n[0];
		res.out_quat_x     = ctx_s15.n[1];
		res.out_quat_y     = ctx_s15.n[2];
		res.out_quat_z     = ctx_s15.n[3];
		res.out_vec_w      = vec[0];
		res.out_vec_x      = vec[1];
		res.out_vec_y      = vec[2];
		res.out_vec_z      = vec[3];
		res.was_normalized = ctx_s15.normd;
		res.saturated      = clip_out;
	end

	always_ff @(posedge clk) begin
		if (en) result <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0;
			for (int i = 1; i <= JOB_DELAY; i++) vld_dl_q[i] <= 1'b0;
			vld_s4 <= 1'b0; vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0;
			vld_s8 <= 1'b0; vld_s9 <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0;
			vld_s12 <= 1'b0; vld_s13 <= 1'b0; vld_s14 <= 1'b0; vld_s15 <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= head_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_dl_q[1] <= vld_s3;
			for (int i = 2; i <= JOB_DELAY; i++) vld_dl_q[i] <= vld_dl_q[i-1];
			vld_s4  <= vld_dl_q[JOB_DELAY];
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
			result_valid <= vld_s15;
		end
	end

endmodule

### hw/rtl/quaternion_constraint_stabilizer_unit.sv
// Top level of the quaternion constraint stabilizer: APB register file, front
// queue and back pipeline. Depends on qcs_pkg, qcs_front and qcs_back.
//
//   Channel  Direction  Handshake                 Payload
//   item     in         item_valid/item_ready     qcs_in_t
//   result   out        result_valid/result_ready qcs_out_t
//   config   in         APB psel/penable/pwrite   32-bit gains at 0x0 and 0x4
//
// One transaction can be taken every cycle while the queue is not full. Most
// of the pipeline depth comes from the bit-serial square root (33 stages)
// and the shared-divisor divider (25 stages).
// A stalled result register freezes the whole back pipeline; the four-entry
// queue keeps accepting until it fills. Reset clears the queue, every valid
// bit and both gains to zero.
module quaternion_constraint_stabilizer_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  qcs_pkg::qcs_in_t  item,
	output logic              result_valid,
	input  logic              result_ready,
	output qcs_pkg::qcs_out_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import qcs_pkg::*;

	localparam logic REG_POSITION_GAIN = 1'b0;
	localparam logic REG_VELOCITY_GAIN = 1'b1;

	logic [31:0] position_gain_q;
	logic [31:0] velocity_gain_q;
	logic        head_valid;
	qcs_job_t    head;
	logic        pop;

	// The APB port never waits. Register selection uses address bit 2 only.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VELOCITY_GAIN) ? velocity_gain_q : position_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_gain_q <= '0;
			velocity_gain_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_POSITION_GAIN) position_gain_q <= pwdata;
			else velocity_gain_q <= pwdata;
		end
	end

	// The front classifies and queues transactions; the back pops one
	// whenever its pipeline advances.
	qcs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	qcs_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.position_gain (position_gain_q),
		.velocity_gain (velocity_gain_q),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result        (result)
	);

	// A normalized quaternion never has a component beyond one.
	property p_unit_norm;
		@(posedge clk) disable iff (!arst_n)
		(result_valid && result.was_normalized) |->
			($signed(result.out_quat_w) <= 32'sd16777216 &&
			 $signed(result.out_quat_w) >= -32'sd16777216 &&
			 $signed(result.out_quat_x) <= 32'sd16777216 &&
			 $signed(result.out_quat_x) >= -32'sd16777216 &&
			 $signed(result.out_quat_y) <= 32'sd16777216 &&
			 $signed(result.out_quat_y) >= -32'sd16777216 &&
			 $signed(result.out_quat_z) <= 32'sd16777216 &&
			 $signed(result.out_quat_z) >= -32'sd16777216);
	endproperty
	a_unit_norm: assert property (p_unit_norm) else $error("normalized component above one");

	// The back may only pop a queue entry that exists.
	property p_pop_valid;
		@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid;
	endproperty
	a_pop_valid: assert property (p_pop_valid) else $error("pop from empty queue");

endmodule
